/* rtl/core/wsjof_pkg.sv */
package wsjof_pkg;

  // Window geometry
  localparam int WINDOW = 8;
  localparam int WIN_AW = $clog2(WINDOW);
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int SCAN_LAST = WINDOW + 1;
  localparam int CNT_W = $clog2(SCAN_LAST + 1);

  // Field and register widths
  localparam int SAMPLE_W = 20;
  localparam int THRESH_W = 19;
  localparam int RATIO_W = 15;
  localparam int SIGMA_W = 12;
  localparam int FLAG_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 19;

  // Datapath widths and shifts, most derived from the window size
  localparam int SUM_W = SAMPLE_W + WIN_AW;
  localparam int SQ_W = 2 * SAMPLE_W - 1 + WIN_AW;
  localparam int D_W = SUM_W + 1;
  localparam int MAG_W = SUM_W;
  localparam int Q_W = 2 * SAMPLE_W - 1 + 2 * WIN_AW;
  localparam int MUL_W = (SUM_W > 2 * SIGMA_W) ? SUM_W : 2 * SIGMA_W;
  localparam int PROD_W = 2 * MUL_W;
  localparam int Q_LO_W = MUL_W;
  localparam int Q_HI_W = Q_W - Q_LO_W;
  localparam int S2_W = 2 * SIGMA_W;
  localparam int R_LO_W = S2_W + Q_LO_W;
  localparam int R_HI_W = S2_W + Q_HI_W;
  localparam int CMP_W = S2_W + Q_W;
  localparam int D2_W = 2 * MAG_W;
  localparam int DIFF_W = SAMPLE_W;
  localparam int Z_SHIFT = 16;
  localparam int RATIO_SHIFT = 8;

  // Jump test constants
  localparam int JUMP_MIN_FILL = 4;
  localparam logic signed [SAMPLE_W-1:0] NEAR_LIMIT = 20'sd10;
  localparam logic [RATIO_W-1:0] RATIO_CAP = 15'd25574;

  // Register reset values
  localparam logic [THRESH_W-1:0] JUMP_THRESHOLD_RST = 19'd500;
  localparam logic [RATIO_W-1:0] JUMP_RATIO_RST = 15'd77;
  localparam logic [SIGMA_W-1:0] SIGMA_LIMIT_RST = 12'd768;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_JUMP_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_JUMP_RATIO = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGMA_LIMIT = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SIG2,
    ST_SUM2,
    ST_D2,
    ST_QLO,
    ST_QHI,
    ST_RAT,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    MUL_SQ,
    MUL_SIG,
    MUL_SUM,
    MUL_D,
    MUL_QLO,
    MUL_QHI,
    MUL_RAT
  } mul_op_t;

  typedef struct packed {
    logic              take;
    logic              rd_en;
    logic [WIN_AW-1:0] rd_addr;
    logic              acc_sum;
    logic              acc_sq;
    mul_op_t           mul_op;
    logic              ld_diff;
    logic              ld_s2d;
    logic              ld_q;
    logic              ld_d2;
    logic              ld_rlo;
    logic              ld_rhs;
    logic              commit;
  } cmd_t;

endpackage

/* rtl/core/window_sigma_jump_outlier_flag.sv */
// Channel  Handshake             Payload
// -------  --------------------  ----------------------------------------------
// input    in_valid / in_ready   sample
// output   out_valid / out_ready flagged, jump_hit, sigma_hit, flag_total
// config   cfg_we                cfg_index, cfg_data (no wait, no read-back)
//
// One sample at a time, taken once the last has committed; the window is
// read one entry a cycle from its memory port, then the shared 24 x 24
// multiplier runs the six variance and jump products in turn.
// Reset (rst, synchronous) clears control, history and the flag count and
// loads the register defaults; window contents are not cleared.
// A new sample is taken while a finished result still waits on out_ready;
// only the commit of the next result waits for the output register.
module window_sigma_jump_outlier_flag (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [wsjof_pkg::SAMPLE_W-1:0] sample,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  flagged,
  output logic                                  jump_hit,
  output logic                                  sigma_hit,
  output logic [wsjof_pkg::FLAG_W-1:0]          flag_total,
  input  logic                                  cfg_we,
  input  logic [wsjof_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wsjof_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import wsjof_pkg::*;

  cmd_t cmd;

  // Sequence each transaction
  wsjof_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Window store, arithmetic and result register
  wsjof_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample     (sample),
    .flagged    (flagged),
    .jump_hit   (jump_hit),
    .sigma_hit  (sigma_hit),
    .flag_total (flag_total)
  );

endmodule

/* rtl/core/wsjof_ctrl.sv */
module wsjof_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output wsjof_pkg::cmd_t  cmd
);
  import wsjof_pkg::*;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] scan_cnt;
  logic [CNT_W-1:0] scan_cnt_next;
  logic             out_valid_next;
  logic             slot_free;

  assign in_ready  = (state == ST_IDLE);
  assign slot_free = !out_valid || out_ready;

  // State, scan counter and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      scan_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      scan_cnt  <= scan_cnt_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_SCAN;
      ST_SCAN: if (scan_cnt == CNT_W'(SCAN_LAST)) state_next = ST_SIG2;
      ST_SIG2: state_next = ST_SUM2;
      ST_SUM2: state_next = ST_D2;
      ST_D2:   state_next = ST_QLO;
      ST_QLO:  state_next = ST_QHI;
      ST_QHI:  state_next = ST_RAT;
      ST_RAT:  state_next = ST_DONE;
      ST_DONE: if (slot_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Advance the scan counter through the window reads
  always_comb begin
    scan_cnt_next = '0;
    if (state == ST_SCAN && scan_cnt != CNT_W'(SCAN_LAST)) begin
      scan_cnt_next = scan_cnt + 1'b1;
    end
  end

  // Hold the result valid until the transaction completes
  always_comb begin
    out_valid_next = out_valid;
    if (out_ready) out_valid_next = 1'b0;
    if (cmd.commit) out_valid_next = 1'b1;
  end

  // Commands to the datapath
  always_comb begin
    cmd         = '0;
    cmd.mul_op  = MUL_SQ;
    cmd.rd_addr = scan_cnt[WIN_AW-1:0];
    unique case (state)
      ST_IDLE: cmd.take = in_valid;
      ST_SCAN: begin
        cmd.rd_en   = (scan_cnt < CNT_W'(WINDOW));
        cmd.acc_sum = (scan_cnt >= CNT_W'(1)) && (scan_cnt <= CNT_W'(WINDOW));
        cmd.acc_sq  = (scan_cnt >= CNT_W'(2));
      end
      ST_SIG2: begin
        cmd.mul_op  = MUL_SIG;
        cmd.ld_diff = 1'b1;
      end
      ST_SUM2: begin
        cmd.mul_op = MUL_SUM;
        cmd.ld_s2d = 1'b1;
      end
      ST_D2: begin
        cmd.mul_op = MUL_D;
        cmd.ld_q   = 1'b1;
      end
      ST_QLO: begin
        cmd.mul_op = MUL_QLO;
        cmd.ld_d2  = 1'b1;
      end
      ST_QHI: begin
        cmd.mul_op = MUL_QHI;
        cmd.ld_rlo = 1'b1;
      end
      ST_RAT: begin
        cmd.mul_op = MUL_RAT;
        cmd.ld_rhs = 1'b1;
      end
      ST_DONE: begin
        cmd.mul_op = MUL_RAT;
        cmd.commit = slot_free;
      end
      default: cmd.take = 1'b0;
    endcase
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("item accepted while another is in flight");

  a_commit_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("result committed over an untaken result");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (scan_cnt <= CNT_W'(SCAN_LAST)))
    else $error("scan counter ran past the window");

endmodule

/* rtl/core/wsjof_dp.sv */
module wsjof_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  wsjof_pkg::cmd_t                       cmd,
  input  logic                                  cfg_we,
  input  logic [wsjof_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wsjof_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic signed [wsjof_pkg::SAMPLE_W-1:0] sample,
  output logic                                  flagged,
  output logic                                  jump_hit,
  output logic                                  sigma_hit,
  output logic [wsjof_pkg::FLAG_W-1:0]          flag_total
);
  import wsjof_pkg::*;

  localparam logic signed [D_W-1:0] WIN_D = D_W'(WINDOW);

  // Configuration registers
  logic [THRESH_W-1:0] jump_threshold;
  logic [RATIO_W-1:0]  jump_ratio;
  logic [SIGMA_W-1:0]  sigma_limit;

  // Block state
  logic signed [SAMPLE_W-1:0] window_store [WINDOW];
  logic [WIN_AW-1:0]          write_slot;
  logic [FILL_W-1:0]          fill_count;
  logic signed [SAMPLE_W-1:0] previous_sample;
  logic                       previous_valid;
  logic [FLAG_W-1:0]          flag_counter;

  // Working registers
  logic signed [SAMPLE_W-1:0] rd_data;
  logic signed [SAMPLE_W-1:0] cur;
  logic signed [SUM_W-1:0]    sum;
  logic [SQ_W-1:0]            sq;
  logic [PROD_W-1:0]          prod;
  logic [DIFF_W-1:0]          diff;
  logic [S2_W-1:0]            s2;
  logic signed [D_W-1:0]      dev;
  logic [Q_W-1:0]             q;
  logic [D2_W-1:0]            d2;
  logic [R_LO_W-1:0]          rlo;
  logic [CMP_W-1:0]           rhs;

  // Combinational terms
  logic [MUL_W-1:0]           mul_a;
  logic [MUL_W-1:0]           mul_b;
  logic [SAMPLE_W-1:0]        rd_mag;
  logic [MAG_W-1:0]           sum_mag;
  logic [MAG_W-1:0]           dev_mag;
  logic signed [SAMPLE_W:0]   step;
  logic [SAMPLE_W:0]          step_mag;
  logic [CMP_W-1:0]           lhs;
  logic                       rel_ok;
  logic                       jump_now;
  logic                       sigma_now;
  logic                       hit_now;
  logic [FLAG_W-1:0]          flag_counter_next;

  assign rd_mag   = rd_data[SAMPLE_W-1] ? SAMPLE_W'(-rd_data) : SAMPLE_W'(rd_data);
  assign sum_mag  = sum[SUM_W-1] ? MAG_W'(-sum) : MAG_W'(sum);
  assign dev_mag  = dev[D_W-1] ? MAG_W'(-dev) : MAG_W'(dev);
  assign step     = (SAMPLE_W+1)'(cur) - (SAMPLE_W+1)'(previous_sample);
  assign step_mag = step[SAMPLE_W] ? (SAMPLE_W+1)'(-step) : (SAMPLE_W+1)'(step);

  // Write configuration registers; drop writes beyond the list
  always_ff @(posedge clk) begin
    if (rst) begin
      jump_threshold <= JUMP_THRESHOLD_RST;
      jump_ratio     <= JUMP_RATIO_RST;
      sigma_limit    <= SIGMA_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_JUMP_THRESHOLD: jump_threshold <= cfg_data[THRESH_W-1:0];
        CFG_JUMP_RATIO:     jump_ratio     <= cfg_data[RATIO_W-1:0];
        CFG_SIGMA_LIMIT:    sigma_limit    <= cfg_data[SIGMA_W-1:0];
        default:            jump_threshold <= jump_threshold;
      endcase
    end
  end

  // Window memory: registered read, write on commit
  always_ff @(posedge clk) begin
    if (cmd.rd_en) rd_data <= window_store[cmd.rd_addr];
    if (cmd.commit) window_store[write_slot] <= cur;
  end

  // Select multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_op)
      MUL_SQ: begin
        mul_a = MUL_W'(rd_mag);
        mul_b = MUL_W'(rd_mag);
      end
      MUL_SIG: begin
        mul_a = MUL_W'(sigma_limit);
        mul_b = MUL_W'(sigma_limit);
      end
      MUL_SUM: begin
        mul_a = MUL_W'(sum_mag);
        mul_b = MUL_W'(sum_mag);
      end
      MUL_D: begin
        mul_a = MUL_W'(dev_mag);
        mul_b = MUL_W'(dev_mag);
      end
      MUL_QLO: begin
        mul_a = MUL_W'(s2);
        mul_b = MUL_W'(q[Q_LO_W-1:0]);
      end
      MUL_QHI: begin
        mul_a = MUL_W'(s2);
        mul_b = MUL_W'(q[Q_W-1:Q_LO_W]);
      end
      MUL_RAT: begin
        mul_a = MUL_W'(jump_ratio);
        mul_b = MUL_W'(previous_sample[SAMPLE_W-2:0]);
      end
      default: mul_a = '0;
    endcase
  end

  // Shared multiplier with registered product
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Accumulate the window and build the variance terms step by step
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      cur <= sample;
      sum <= '0;
      sq  <= '0;
    end
    if (cmd.acc_sum) sum <= sum + SUM_W'(rd_data);
    if (cmd.acc_sq) sq <= sq + prod[SQ_W-1:0];
    if (cmd.ld_diff) diff <= step_mag[DIFF_W-1:0];
    if (cmd.ld_s2d) begin
      s2  <= prod[S2_W-1:0];
      dev <= D_W'(D_W'(cur) * WIN_D) - D_W'(sum);
    end
    if (cmd.ld_q) q <= Q_W'(Q_W'(sq) * Q_W'(WINDOW)) - prod[Q_W-1:0];
    if (cmd.ld_d2) d2 <= prod[D2_W-1:0];
    if (cmd.ld_rlo) rlo <= prod[R_LO_W-1:0];
    if (cmd.ld_rhs) rhs <= CMP_W'(rlo) + (CMP_W'(prod[R_HI_W-1:0]) << Q_LO_W);
  end

  // Decide both tests; prod holds jump_ratio * previous sample here
  always_comb begin
    lhs = CMP_W'(d2) << Z_SHIFT;
    if (previous_sample > NEAR_LIMIT) begin
      rel_ok = ((PROD_W'(diff) << RATIO_SHIFT) > prod);
    end else begin
      rel_ok = (diff > DIFF_W'(NEAR_LIMIT)) && (jump_ratio <= RATIO_CAP);
    end
    jump_now  = previous_valid && (32'(fill_count) >= JUMP_MIN_FILL) &&
                (diff > DIFF_W'(jump_threshold)) && rel_ok;
    sigma_now = (fill_count == FILL_W'(WINDOW)) && (q != '0) && (lhs > rhs);
    hit_now   = jump_now || sigma_now;
    flag_counter_next = flag_counter;
    if (hit_now && flag_counter != '1) flag_counter_next = flag_counter + 1'b1;
  end

  // Advance the ring and history on commit
  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot      <= '0;
      fill_count      <= '0;
      previous_sample <= '0;
      previous_valid  <= 1'b0;
      flag_counter    <= '0;
    end else if (cmd.commit) begin
      write_slot      <= (write_slot == WIN_AW'(WINDOW - 1)) ? '0 : write_slot + 1'b1;
      if (fill_count != FILL_W'(WINDOW)) fill_count <= fill_count + 1'b1;
      previous_sample <= cur;
      previous_valid  <= 1'b1;
      flag_counter    <= flag_counter_next;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      flagged    <= hit_now;
      jump_hit   <= jump_now;
      sigma_hit  <= sigma_now;
      flag_total <= flag_counter_next;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FILL_W'(WINDOW))
    else $error("fill count passed the window size");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && !hit_now) |=> (flag_counter == $past(flag_counter)))
    else $error("flag count moved on an unflagged sample");

  a_slot_tracks_fill: assert property (@(posedge clk) disable iff (rst)
    (fill_count != FILL_W'(WINDOW)) |-> (write_slot == fill_count[WIN_AW-1:0]))
    else $error("write slot out of step with the fill count");

endmodule

/* tb/window_sigma_jump_outlier_flag_tb.sv */
module window_sigma_jump_outlier_flag_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wsjof_pkg::*;

  localparam int CLK_HALF = 5;
  localparam int RESET_CYCLES = 9;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS = 300;
  localparam int PHASE_COUNT = 6;
  localparam int FLAG_MAX = (1 << FLAG_W) - 1;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  // index just past the register list; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic              flagged;
    logic              jump_hit;
    logic              sigma_hit;
    logic [FLAG_W-1:0] flag_total;
  } verdict_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic                       typed;
    verdict_t                   want;
  } stim_row_t;

  localparam verdict_t QUIET_VERDICT = '{1'b0, 1'b0, 1'b0, '0};

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b1;
  logic                       flagged;
  logic                       jump_hit;
  logic                       sigma_hit;
  logic [FLAG_W-1:0]          flag_total;
  logic                       cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;

  // Detector state mirrored by the predictor
  logic signed [SAMPLE_W-1:0] ring [WINDOW];
  int                         ring_slot;
  int                         ring_fill;
  logic signed [SAMPLE_W-1:0] last_sample;
  logic                       have_last;
  int                         flag_count;
  logic [THRESH_W-1:0]        thr_reg;
  logic [RATIO_W-1:0]         ratio_reg;
  logic [SIGMA_W-1:0]         sigma_reg;

  verdict_t                   pending_verdicts[$];

  // Stimulus shaping and bookkeeping
  logic                       idle_on = 1'b0;
  int                         level = 1000;
  int                         noise_amp = 40;
  int                         hold_left = 0;
  logic signed [SAMPLE_W-1:0] drawn = '0;
  int                         items_sent = 0;
  int                         results_seen = 0;
  int                         jump_seen = 0;
  int                         sigma_seen = 0;
  int                         fail_count = 0;
  int                         quiet_cycles = 0;

  stim_row_t                  directed_rows[24];

  window_sigma_jump_outlier_flag uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample     (sample),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .flagged    (flagged),
    .jump_hit   (jump_hit),
    .sigma_hit  (sigma_hit),
    .flag_total (flag_total),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // Judge one sample against the mirrored state, then advance that state
  function automatic verdict_t judge_sample(logic signed [SAMPLE_W-1:0] s);
    longint   v, prev, diff, total, squares, spread, dev, x;
    logic [127:0] lhs, rhs;
    logic     jump, sigma, rel;
    verdict_t r;
    v = s;
    jump = 1'b0;
    sigma = 1'b0;

    // jump test: absolute step plus relative step against the previous sample
    if (have_last && ring_fill >= JUMP_MIN_FILL) begin
      prev = last_sample;
      diff = (v > prev) ? v - prev : prev - v;
      if (prev > NEAR_LIMIT)
        rel = (diff << RATIO_SHIFT) > longint'(ratio_reg) * prev;
      else
        rel = (diff > NEAR_LIMIT) && (ratio_reg <= RATIO_CAP);
      jump = (diff > longint'(thr_reg)) && rel;
    end

    // sigma test on a full window, skipped when the window is flat
    if (ring_fill == WINDOW) begin
      total = 0;
      squares = 0;
      for (int i = 0; i < WINDOW; i++) begin
        x = ring[i];
        total += x;
        squares += x * x;
      end
      spread = WINDOW * squares - total * total;
      if (spread > 0) begin
        dev = WINDOW * v - total;
        if (dev < 0)
          dev = -dev;
        lhs = dev;
        lhs = (lhs * lhs) << Z_SHIFT;
        rhs = sigma_reg;
        rhs = rhs * sigma_reg;
        rhs = rhs * spread;
        sigma = lhs > rhs;
      end
    end

    ring[ring_slot] = s;
    ring_slot = (ring_slot + 1) % WINDOW;
    if (ring_fill < WINDOW)
      ring_fill++;
    last_sample = s;
    have_last = 1'b1;
    if ((jump || sigma) && flag_count < FLAG_MAX)
      flag_count++;
    jump_seen += jump;
    sigma_seen += sigma;

    r.flagged = jump | sigma;
    r.jump_hit = jump;
    r.sigma_hit = sigma;
    r.flag_total = FLAG_W'(flag_count);
    return r;
  endfunction

  // Next random reading: mostly steady traces, with spikes, flat runs and noise
  function automatic logic signed [SAMPLE_W-1:0] draw_sample();
    int pick, x;
    if (hold_left > 0) begin
      hold_left--;
      return drawn;
    end
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      // flat stretch, long enough to leave the window with no variance
      hold_left = $urandom_range(8, 14);
      x = drawn;
    end else if (pick < 60) begin
      if ($urandom_range(0, 39) == 0) begin
        level = int'($urandom_range(0, 301000)) - 1000;
        noise_amp = $urandom_range(1, 2000);
      end
      x = level + int'($urandom_range(0, 2 * noise_amp)) - noise_amp;
    end else if (pick < 72) begin
      x = level + int'($urandom_range(0, 200000)) - 100000;
    end else if (pick < 84) begin
      x = int'($urandom_range(0, 30)) - 15;
    end else if (pick < 94) begin
      x = int'($urandom_range(0, (1 << SAMPLE_W) - 1)) + int'(SAMPLE_MIN);
    end else begin
      case ($urandom_range(0, 3))
        0:       x = SAMPLE_MIN;
        1:       x = SAMPLE_MAX;
        2:       x = 0;
        default: x = -1;
      endcase
    end
    if (x > int'(SAMPLE_MAX))
      x = SAMPLE_MAX;
    else if (x < int'(SAMPLE_MIN))
      x = SAMPLE_MIN;
    drawn = SAMPLE_W'(x);
    return drawn;
  endfunction

  // Offer one sample; hold valid and payload until the transaction completes
  task automatic send_sample(logic signed [SAMPLE_W-1:0] value, logic typed, verdict_t want);
    verdict_t predicted;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample <= value;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    predicted = judge_sample(value);
    pending_verdicts.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  // Drop valid and hold off until every outstanding result has arrived
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0)
      @(posedge clk);
  endtask

  // Write all three registers, then a stray write past the list
  task automatic apply_settings(logic [CFG_DATA_W-1:0] thr, logic [CFG_DATA_W-1:0] ratio,
                                logic [CFG_DATA_W-1:0] sig);
    cfg_we <= 1'b1;
    cfg_index <= CFG_JUMP_THRESHOLD;
    cfg_data <= thr;
    @(posedge clk);
    cfg_index <= CFG_JUMP_RATIO;
    cfg_data <= ratio;
    @(posedge clk);
    cfg_index <= CFG_SIGMA_LIMIT;
    cfg_data <= sig;
    @(posedge clk);
    cfg_index <= CFG_SPARE;
    cfg_data <= CFG_DATA_W'($urandom());
    @(posedge clk);
    cfg_we <= 1'b0;
    thr_reg = thr[THRESH_W-1:0];
    ratio_reg = ratio[RATIO_W-1:0];
    sigma_reg = sig[SIGMA_W-1:0];
  endtask

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Output side: stall in random bursts while idling is on
  initial begin
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // Compare each completed result transaction with the oldest prediction
  always @(posedge clk) begin : result_check
    verdict_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_verdicts.size() == 0) begin
        fail_count++;
        $error("result with no sample outstanding: flagged %0b, flag_total %0d",
               flagged, flag_total);
      end else begin
        want = pending_verdicts.pop_front();
        check_field("flagged", want.flagged, flagged);
        check_field("jump_hit", want.jump_hit, jump_hit);
        check_field("sigma_hit", want.sigma_hit, sigma_hit);
        check_field("flag_total", want.flag_total, flag_total);
      end
    end
  end

  // Abort if neither channel moves a transaction for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $error("no transaction for %0d cycles, %0d results outstanding",
             QUIET_LIMIT, pending_verdicts.size());
      $display("** window_sigma_jump_outlier_flag: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    // predictor starts from the reset state
    ring_slot = 0;
    ring_fill = 0;
    last_sample = '0;
    have_last = 1'b0;
    flag_count = 0;
    thr_reg = JUMP_THRESHOLD_RST;
    ratio_reg = JUMP_RATIO_RST;
    sigma_reg = SIGMA_LIMIT_RST;

    // First four samples cannot flag: too little history for either test.
    // The rest exercise near-zero previous samples, a flat window and both
    // extremes, all under the reset register values.
    directed_rows = '{
      '{SAMPLE_MIN,    1'b1, QUIET_VERDICT},
      '{SAMPLE_MAX,    1'b1, QUIET_VERDICT},
      '{20'sd0,        1'b1, QUIET_VERDICT},
      '{-20'sd1,       1'b1, QUIET_VERDICT},
      '{20'sd5,        1'b0, QUIET_VERDICT},
      '{20'sd600,      1'b0, QUIET_VERDICT},
      '{20'sd600,      1'b0, QUIET_VERDICT},
      '{20'sd1200,     1'b0, QUIET_VERDICT},
      '{20'sd1200,     1'b0, QUIET_VERDICT},
      '{20'sd100,      1'b0, QUIET_VERDICT},
      '{20'sd100,      1'b0, QUIET_VERDICT},
      '{20'sd100,      1'b0, QUIET_VERDICT},
      '{20'sd100,      1'b0, QUIET_VERDICT},
      '{20'sd100,      1'b0, QUIET_VERDICT},
      '{20'sd100,      1'b0, QUIET_VERDICT},
      '{20'sd100,      1'b0, QUIET_VERDICT},
      '{20'sd100,      1'b0, QUIET_VERDICT},
      '{20'sd300000,   1'b0, QUIET_VERDICT},
      '{20'sd100,      1'b0, QUIET_VERDICT},
      '{20'sd7,        1'b0, QUIET_VERDICT},
      '{20'sd3,        1'b0, QUIET_VERDICT},
      '{20'sd20,       1'b0, QUIET_VERDICT},
      '{SAMPLE_MIN,    1'b0, QUIET_VERDICT},
      '{SAMPLE_MAX,    1'b0, QUIET_VERDICT}
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    idle_on = 1'b1;
    foreach (directed_rows[i])
      send_sample(directed_rows[i].value, directed_rows[i].typed, directed_rows[i].want);

    // Random phases, each under its own register setting
    for (int p = 0; p < PHASE_COUNT; p++) begin
      drain_results();
      case (p)
        0: apply_settings('0, '0, '0);
        // ratio and sigma data carry bits above the register width
        1: apply_settings({CFG_DATA_W{1'b1}}, {CFG_DATA_W{1'b1}}, {7'h2A, 12'hFFF});
        2: apply_settings(19'd200, CFG_DATA_W'(RATIO_CAP), 19'd512);
        3: apply_settings(19'd50, CFG_DATA_W'(RATIO_CAP) + 19'd1, 19'd256);
        4: apply_settings(CFG_DATA_W'($urandom_range(0, 3000)),
                          CFG_DATA_W'($urandom_range(0, 600)),
                          CFG_DATA_W'($urandom_range(128, 1536)));
        default: apply_settings(CFG_DATA_W'(JUMP_THRESHOLD_RST), CFG_DATA_W'(JUMP_RATIO_RST),
                                CFG_DATA_W'(SIGMA_LIMIT_RST));
      endcase
      idle_on = (p < PHASE_COUNT - 1);
      repeat (PHASE_ITEMS)
        send_sample(draw_sample(), 1'b0, QUIET_VERDICT);
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d samples (%0d directed) under the reset values and %0d written settings,",
             items_sent, $size(directed_rows), PHASE_COUNT);
    $display("stalls on both sides; %0d results checked, %0d jump, %0d sigma hits, %0d errors",
             results_seen, jump_seen, sigma_seen, fail_count);
    if (fail_count == 0 && pending_verdicts.size() == 0) begin
      $display("** window_sigma_jump_outlier_flag: PASSED **");
    end else begin
      $display("** window_sigma_jump_outlier_flag: FAILED **");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/wsjof_pkg.sv
rtl/core/wsjof_ctrl.sv
rtl/core/wsjof_dp.sv
rtl/core/window_sigma_jump_outlier_flag.sv
tb/window_sigma_jump_outlier_flag_tb.sv
